/* rtl/pva_pkg.sv */
package pva_pkg;

   // voice and key store sizes
   localparam int VOICES = 16;
   localparam int KEYS   = 128;

   localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;

   // fixed field widths
   localparam int FUNC_W   = 2;
   localparam int NOTE_W   = 8;
   localparam int FIN_W    = 4;
   localparam int STATUS_W = 3;
   localparam int AV_W     = 5;

   // wide enough for the voice count and the active_voices register
   localparam int VCNT_W = ($clog2(VOICES + 1) > AV_W) ? $clog2(VOICES + 1) : AV_W;

   // csr port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam int REG_IDX_W = PADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_VOICES = REG_IDX_W'(0);
   localparam logic [AV_W-1:0]      AV_RESET          = AV_W'(16);

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FINISH   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] RSP_FREE     = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_STOLEN   = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_RETRIG   = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_IGNORED  = 3'd4;
   localparam logic [STATUS_W-1:0] RSP_REJECTED = 3'd5;
   localparam logic [STATUS_W-1:0] RSP_FINISHED = 3'd6;

   typedef enum logic [1:0] {
      STAGE_FINISHED = 2'd0,
      STAGE_ACTIVE   = 2'd1,
      STAGE_RELEASE  = 2'd2
   } stage_type;

   // broadcast from the controller to every voice cell
   typedef struct packed {
      logic                 set_stage;
      logic                 set_owner;
      logic [VOICE_W-1:0]   sel;
      stage_type            stage;
      logic [KEY_W-1:0]     owner_key;
      logic                 load_token;
      logic [VOICE_W-1:0]   token_start;
      logic                 shift_token;
   } cell_cmd_type;

   // what one voice cell reports back
   typedef struct packed {
      logic             owner_valid;
      logic [KEY_W-1:0] owner_key;
      stage_type        stage;
   } cell_stat_type;

endpackage

/* rtl/poly_voice_allocator.sv */
// channel   direction  handshake            word
// req       in         req_valid/req_ready  func, note, finished_voice
// rsp       out        rsp_valid/rsp_ready  voice, status, evicted_valid, evicted_key
// csr       in/out     apb, pready tied 1   active_voices at byte address 0
//
// flow: finish, reject and no-op go from idle to commit; note off and retrigger pass
// through lookup; a note-on that needs a new voice also walks the search token in scan,
// over 1 up to the active count of voices; a new word is taken only in the idle state
// reset: synchronous; key map valid bits and all voice cells clear at once
// stalls: one result register; a finished word waits in the commit state while
// the result register is still held by rsp_ready low
module poly_voice_allocator import pva_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [NOTE_W-1:0]   req_note,
   input  logic [FIN_W-1:0]    req_finished_voice,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VOICE_W-1:0]  rsp_voice,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_evicted_valid,
   output logic [KEY_W-1:0]    rsp_evicted_key,

   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_SCAN,
      S_COMMIT
   } state_type;

   // what the commit step does to the voice cells and the key map
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_STAGE,
      ACT_ASSIGN
   } act_type;

   // ---------------------------------------------------------------
   // csr: active_voices
   // ---------------------------------------------------------------
   logic [AV_W-1:0]      av_ff, av_in;
   logic                 csr_write;
   logic                 csr_hit;
   logic [VCNT_W-1:0]    vcnt;

   assign csr_hit   = (paddr[PADDR_W-1:2] == REG_ACTIVE_VOICES);
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? PDATA_W'(av_ff) : '0;

   always_comb begin
      av_in = av_ff;
      if (csr_write) begin
         av_in = pwdata[AV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= AV_RESET;
      end else begin
         av_ff <= av_in;
      end
   end

   // zero acts as one, anything above the cell count as the cell count
   always_comb begin
      if (av_ff == '0) begin
         vcnt = VCNT_W'(1);
      end else if (VCNT_W'(av_ff) > VCNT_W'(VOICES)) begin
         vcnt = VCNT_W'(VOICES);
      end else begin
         vcnt = VCNT_W'(av_ff);
      end
   end

   // ---------------------------------------------------------------
   // key map: valid bits in flops, voice index in a ram
   // ---------------------------------------------------------------
   logic [KEYS-1:0]    map_valid_ff, map_valid_in;
   logic               map_set;
   logic               map_clr;
   logic [KEY_W-1:0]   map_clr_key;
   logic [VOICE_W-1:0] map_rd_voice;
   logic [KEY_W-1:0]   map_rd_addr;
   logic [VOICE_W-1:0] rsp_voice_in_w;

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [KEY_W-1:0]   key_ff, key_in;

   assign map_rd_addr = req_note[KEY_W-1:0];

   pva_ram #(
      .WIDTH (VOICE_W),
      .DEPTH (KEYS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_set),
      .wr_addr (key_ff),
      .wr_data (rsp_voice_in_w),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_voice)
   );

   always_comb begin
      map_valid_in = map_valid_ff;
      // a set of the new key wins over the eviction of the old one
      if (map_clr) begin
         map_valid_in[map_clr_key] = 1'b0;
      end
      if (map_set) begin
         map_valid_in[key_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
      end else begin
         map_valid_ff <= map_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // chain of voice cells; the search token walks from cell to cell
   // and wraps from the last active cell back to cell zero
   // ---------------------------------------------------------------
   cell_cmd_type       cell_cmd;
   cell_stat_type      cell_stat [VOICES];
   logic [VOICES-1:0]  tok_in;
   logic [VOICES-1:0]  tok_out;
   logic [VOICES-1:0]  free_vec;
   logic [VOICE_W-1:0] last_idx;
   logic               scan_hit;

   assign last_idx = VOICE_W'(vcnt - VCNT_W'(1));

   for (genvar gi = 0; gi < VOICES; gi++) begin : g_cell
      if (gi == 0) begin : g_wrap
         assign tok_in[gi] = tok_out[last_idx];
      end else begin : g_link
         // cells past the active count never take the token
         assign tok_in[gi] = tok_out[gi-1] & (VCNT_W'(gi) < vcnt);
      end

      pva_voice_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (VOICE_W'(gi)),
         .cmd       (cell_cmd),
         .token_in  (tok_in[gi]),
         .token_out (tok_out[gi]),
         .stat      (cell_stat[gi])
      );

      assign free_vec[gi] = (cell_stat[gi].stage == STAGE_FINISHED);
   end

   assign scan_hit = |(tok_out & free_vec);

   // ---------------------------------------------------------------
   // controller
   // ---------------------------------------------------------------
   state_type             state_ff, state_in;
   act_type               act_ff, act_in;
   stage_type             act_stage_ff, act_stage_in;
   logic [VOICE_W-1:0]    ptr_ff, ptr_in;
   logic [VOICE_W-1:0]    start_ff, start_in;
   logic [VCNT_W-1:0]     cnt_ff, cnt_in;
   logic [VOICE_W-1:0]    res_voice_ff, res_voice_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VOICE_W-1:0]    rsp_voice_ff, rsp_voice_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [KEY_W-1:0]      rsp_ev_key_ff, rsp_ev_key_in;

   logic [VOICE_W-1:0]    ptr_next;
   logic [VOICE_W-1:0]    steal_voice;
   logic [VOICE_W-1:0]    scan_start;
   logic                  slot_free;
   cell_stat_type         owner;

   assign rsp_voice_in_w = res_voice_ff;

   // round robin step inside the active range
   assign ptr_next = ((VCNT_W'(ptr_ff) + VCNT_W'(1)) == vcnt) ?
                     '0 : ptr_ff + VOICE_W'(1);
   // every active voice busy: take the one after the search start
   assign steal_voice = ((VCNT_W'(start_ff) + VCNT_W'(1)) == vcnt) ?
                        '0 : start_ff + VOICE_W'(1);
   // pointer left beyond a lowered active count restarts at zero
   assign scan_start = (VCNT_W'(ptr_ff) < vcnt) ? ptr_ff : '0;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign owner     = cell_stat[res_voice_ff];

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      act_stage_in  = act_stage_ff;
      ptr_in        = ptr_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      res_voice_in  = res_voice_ff;
      res_status_in = res_status_ff;
      func_in       = func_ff;
      key_in        = key_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_voice_in    = rsp_voice_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_key_in   = rsp_ev_key_ff;

      cell_cmd    = '0;
      map_set     = 1'b0;
      map_clr     = 1'b0;
      map_clr_key = owner.owner_key;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               key_in        = req_note[KEY_W-1:0];
               res_voice_in  = '0;
               res_status_in = RSP_IGNORED;
               act_in        = ACT_NONE;
               act_stage_in  = STAGE_FINISHED;
               state_in      = S_COMMIT;
               case (req_func) inside
                  FUNC_FINISH: begin
                     res_voice_in = VOICE_W'(req_finished_voice);
                     if (VCNT_W'(req_finished_voice) < vcnt) begin
                        res_status_in = RSP_FINISHED;
                        act_in        = ACT_STAGE;
                     end
                  end
                  FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
                     if ({1'b0, req_note} >= (NOTE_W + 1)'(KEYS)) begin
                        res_status_in = RSP_REJECTED;
                     end else begin
                        state_in = S_LOOKUP;
                     end
                  end
                  default: begin
                     // no-op: ignored, nothing changes
                     res_status_in = RSP_IGNORED;
                  end
               endcase
            end
         end

         S_LOOKUP: begin
            // map ram data for key_ff is valid in this cycle
            if (map_valid_ff[key_ff]) begin
               res_voice_in = map_rd_voice;
               act_in       = ACT_STAGE;
               state_in     = S_COMMIT;
               if (func_ff == FUNC_NOTE_ON) begin
                  res_status_in = RSP_RETRIG;
                  act_stage_in  = STAGE_ACTIVE;
               end else begin
                  res_status_in = RSP_RELEASED;
                  act_stage_in  = STAGE_RELEASE;
               end
            end else if (func_ff == FUNC_NOTE_OFF) begin
               state_in = S_COMMIT;
            end else begin
               cell_cmd.load_token  = 1'b1;
               cell_cmd.token_start = scan_start;
               ptr_in               = scan_start;
               start_in             = scan_start;
               cnt_in               = '0;
               state_in             = S_SCAN;
            end
         end

         S_SCAN: begin
            if (scan_hit) begin
               res_voice_in  = ptr_ff;
               res_status_in = RSP_FREE;
               act_in        = ACT_ASSIGN;
               state_in      = S_COMMIT;
            end else if (cnt_ff == vcnt - VCNT_W'(1)) begin
               res_voice_in  = steal_voice;
               res_status_in = RSP_STOLEN;
               act_in        = ACT_ASSIGN;
               state_in      = S_COMMIT;
            end else begin
               cell_cmd.shift_token = 1'b1;
               ptr_in               = ptr_next;
               cnt_in               = cnt_ff + VCNT_W'(1);
            end
         end

         S_COMMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_voice_in    = res_voice_ff;
               rsp_status_in   = res_status_ff;
               rsp_ev_valid_in = 1'b0;
               rsp_ev_key_in   = '0;
               cell_cmd.sel    = res_voice_ff;
               case (act_ff)
                  ACT_STAGE: begin
                     cell_cmd.set_stage = 1'b1;
                     cell_cmd.stage     = act_stage_ff;
                  end
                  ACT_ASSIGN: begin
                     // evict the key the chosen voice held before
                     if (owner.owner_valid) begin
                        map_clr         = 1'b1;
                        rsp_ev_valid_in = 1'b1;
                        rsp_ev_key_in   = owner.owner_key;
                     end
                     map_set            = 1'b1;
                     cell_cmd.set_stage = 1'b1;
                     cell_cmd.stage     = STAGE_ACTIVE;
                     cell_cmd.set_owner = 1'b1;
                     cell_cmd.owner_key = key_ff;
                     ptr_in             = res_voice_ff;
                  end
                  default: begin
                     cell_cmd.set_stage = 1'b0;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff          <= act_in;
      act_stage_ff    <= act_stage_in;
      start_ff        <= start_in;
      cnt_ff          <= cnt_in;
      res_voice_ff    <= res_voice_in;
      res_status_ff   <= res_status_in;
      func_ff         <= func_in;
      key_ff          <= key_in;
      rsp_voice_ff    <= rsp_voice_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_key_ff   <= rsp_ev_key_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voice         = rsp_voice_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_key   = rsp_ev_key_ff;

endmodule

/* rtl/pva_ram.sv */
module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pva_voice_cell.sv */
module pva_voice_cell import pva_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [VOICE_W-1:0] cell_idx,
   input  cell_cmd_type       cmd,
   input  logic               token_in,
   output logic               token_out,
   output cell_stat_type      stat
);

   stage_type        stage_ff, stage_in;
   logic             owner_valid_ff, owner_valid_in;
   logic [KEY_W-1:0] owner_key_ff, owner_key_in;
   logic             token_ff, token_in_nx;
   logic             hit;

   assign hit = (cmd.sel == cell_idx);

   always_comb begin
      stage_in       = stage_ff;
      owner_valid_in = owner_valid_ff;
      owner_key_in   = owner_key_ff;
      token_in_nx    = token_ff;
      if (cmd.set_stage && hit) begin
         stage_in = cmd.stage;
      end
      if (cmd.set_owner && hit) begin
         owner_valid_in = 1'b1;
         owner_key_in   = cmd.owner_key;
      end
      // search token enters at the start voice, then walks to the neighbor
      if (cmd.load_token) begin
         token_in_nx = (cmd.token_start == cell_idx);
      end else if (cmd.shift_token) begin
         token_in_nx = token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= STAGE_FINISHED;
         owner_valid_ff <= 1'b0;
         token_ff       <= 1'b0;
      end else begin
         stage_ff       <= stage_in;
         owner_valid_ff <= owner_valid_in;
         token_ff       <= token_in_nx;
      end
      owner_key_ff <= owner_key_in;
   end

   assign token_out        = token_ff;
   assign stat.owner_valid = owner_valid_ff;
   assign stat.owner_key   = owner_key_ff;
   assign stat.stage       = stage_ff;

endmodule
